// ----- rtl/stl_pkg.sv -----
// ----------------------------------------------------------------------------
// stl_pkg
// Shared types and constants for the script token lexer: request payloads,
// record and class codes, error codes and the character set it recognises.
// ----------------------------------------------------------------------------
package stl_pkg;

    // Result queue depth; the lexer advances only while two slots are free
    localparam int QUEUE_DEPTH = 3;

    // Strings of this many bytes or more are flagged as too long
    localparam int MAX_STRING_BYTES = 64;

    // Record kinds
    localparam logic [1:0] KIND_TEXT  = 2'd0;
    localparam logic [1:0] KIND_TOKEN = 2'd1;
    localparam logic [1:0] KIND_EOS   = 2'd2;

    // Token classes as reported
    localparam logic [3:0] CLASS_STRING  = 4'd0;
    localparam logic [3:0] CLASS_INT     = 4'd1;
    localparam logic [3:0] CLASS_DOUBLE  = 4'd2;
    localparam logic [3:0] CLASS_BOOL    = 4'd3;
    localparam logic [3:0] CLASS_EQUALS  = 4'd4;
    localparam logic [3:0] CLASS_LBRACE  = 4'd5;
    localparam logic [3:0] CLASS_RBRACE  = 4'd6;
    localparam logic [3:0] CLASS_LESS    = 4'd7;
    localparam logic [3:0] CLASS_GREATER = 4'd8;

    // Error codes
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_TOO_LONG = 3'd1;
    localparam logic [2:0] ERR_BAD_INT  = 3'd2;
    localparam logic [2:0] ERR_OVERFLOW = 3'd3;
    localparam logic [2:0] ERR_EOS_OPEN = 3'd4;

    // Characters of interest
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_Y      = 8'h79;
    localparam logic [7:0] CH_E      = 8'h65;
    localparam logic [7:0] CH_S      = 8'h73;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_O      = 8'h6F;

    // Class of the token in progress
    typedef enum logic [1:0] {
        CLS_NONE,
        CLS_STR,
        CLS_INT,
        CLS_DBL
    } cls_t;

    // Input request payload
    typedef struct packed {
        logic [7:0] char_byte;
        logic       stream_end;
    } lex_in_t;

    // Result request payload
    typedef struct packed {
        logic [1:0]         record_kind;
        logic [3:0]         token_class;
        logic [7:0]         text_byte;
        logic signed [63:0] int_value;
        logic               bool_value;
        logic [31:0]        line_number;
        logic [31:0]        column;
        logic [2:0]         error_code;
        logic               last_of_run;
    } lex_out_t;

    // Records handed from the lexer core to the result queue in one cycle
    typedef struct packed {
        logic [1:0] count;
        lex_out_t   first;
        lex_out_t   second;
    } lex_push_t;

endpackage

// ----- rtl/stl_lexer_core.sv -----
// ----------------------------------------------------------------------------
// stl_lexer_core
// Token state and the per-byte update. Turns one buffered byte into zero,
// one or two result records and pushes them to the result queue.
// ----------------------------------------------------------------------------
module stl_lexer_core #(
    parameter int MAX_STRING_BYTES = stl_pkg::MAX_STRING_BYTES
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  stl_pkg::lex_in_t item,
    output stl_pkg::lex_push_t push
);

    // Token and position state
    logic               in_quote_reg, in_quote_next;
    stl_pkg::cls_t      cls_reg, cls_next;
    logic [31:0]        len_reg, len_next;
    logic [63:0]        value_reg, value_next;
    logic               neg_reg, neg_next;
    logic               invalid_reg, invalid_next;
    logic               overflow_reg, overflow_next;
    logic               yes_reg, yes_next;
    logic               no_reg, no_next;
    logic               too_long_reg, too_long_next;
    logic [31:0]        line_reg, line_next;
    logic [31:0]        pos_reg, pos_next;

    logic [7:0]         c;
    logic [7:0]         lc;
    logic               is_digit;
    logic               is_space;
    logic [3:0]         sp_class;
    logic               has_sp;
    logic [31:0]        pos_inc;
    logic [31:0]        col_tok;
    logic [7:0]         yes_char;
    logic [7:0]         no_char;
    logic [67:0]        value_wide;
    logic [67:0]        value_limit;
    stl_pkg::lex_out_t  rec_tok;
    stl_pkg::lex_out_t  rec_sp;
    stl_pkg::lex_out_t  rec_echo;
    stl_pkg::lex_out_t  rec_eos;
    stl_pkg::cls_t      cls_app;
    logic [1:0]         n_rec;
    stl_pkg::lex_out_t  first_rec;
    stl_pkg::lex_out_t  second_rec;

    // Decode the byte
    always_comb
    begin
        c        = item.char_byte;
        lc       = (c >= stl_pkg::CH_UPPER_A && c <= stl_pkg::CH_UPPER_Z) ?
                   (c | 8'h20) : c;
        is_digit = (c >= stl_pkg::CH_ZERO) && (c <= stl_pkg::CH_NINE);
        is_space = (c == stl_pkg::CH_SPACE) ||
                   ((c >= stl_pkg::CH_TAB) && (c <= stl_pkg::CH_CR));
        unique case (c)
            stl_pkg::CH_EQ:     sp_class = stl_pkg::CLASS_EQUALS;
            stl_pkg::CH_LBRACE: sp_class = stl_pkg::CLASS_LBRACE;
            stl_pkg::CH_RBRACE: sp_class = stl_pkg::CLASS_RBRACE;
            stl_pkg::CH_LT:     sp_class = stl_pkg::CLASS_LESS;
            stl_pkg::CH_GT:     sp_class = stl_pkg::CLASS_GREATER;
            default:            sp_class = stl_pkg::CLASS_STRING;
        endcase
        has_sp   = (sp_class != stl_pkg::CLASS_STRING);
        pos_inc  = pos_reg + 32'd1;
        col_tok  = pos_inc - len_reg;
        unique case (len_reg[1:0])
            2'd0:    yes_char = stl_pkg::CH_Y;
            2'd1:    yes_char = stl_pkg::CH_E;
            default: yes_char = stl_pkg::CH_S;
        endcase
        no_char  = len_reg[0] ? stl_pkg::CH_O : stl_pkg::CH_N;
    end

    // Build the finished-token, special-symbol and end-of-stream records
    always_comb
    begin
        rec_tok             = '0;
        rec_tok.record_kind = stl_pkg::KIND_TOKEN;
        rec_tok.line_number = line_reg;
        rec_tok.column      = col_tok;
        unique case (cls_reg)
            stl_pkg::CLS_INT:
            begin
                rec_tok.token_class = stl_pkg::CLASS_INT;
                if (invalid_reg || (neg_reg && len_reg == 32'd1))
                    rec_tok.error_code = stl_pkg::ERR_BAD_INT;
                else if (overflow_reg)
                    rec_tok.error_code = stl_pkg::ERR_OVERFLOW;
                else
                    rec_tok.int_value = $signed(neg_reg ? (64'd0 - value_reg) : value_reg);
            end
            stl_pkg::CLS_DBL:
                rec_tok.token_class = stl_pkg::CLASS_DOUBLE;
            default:
            begin
                if (yes_reg && len_reg == 32'd3)
                begin
                    rec_tok.token_class = stl_pkg::CLASS_BOOL;
                    rec_tok.bool_value  = 1'b1;
                end
                else if (no_reg && len_reg == 32'd2)
                    rec_tok.token_class = stl_pkg::CLASS_BOOL;
                else
                begin
                    rec_tok.token_class = stl_pkg::CLASS_STRING;
                    rec_tok.error_code  = too_long_reg ? stl_pkg::ERR_TOO_LONG
                                                       : stl_pkg::ERR_NONE;
                end
            end
        endcase

        rec_sp             = '0;
        rec_sp.record_kind = stl_pkg::KIND_TOKEN;
        rec_sp.token_class = sp_class;
        rec_sp.line_number = line_reg;
        rec_sp.column      = pos_inc;

        rec_eos             = '0;
        rec_eos.record_kind = stl_pkg::KIND_EOS;
        rec_eos.line_number = line_reg;
        rec_eos.column      = pos_reg;
        rec_eos.error_code  = (cls_reg != stl_pkg::CLS_NONE) ? stl_pkg::ERR_EOS_OPEN
                                                             : stl_pkg::ERR_NONE;
        rec_eos.last_of_run = 1'b1;
    end

    // Class after appending, and the echo record
    always_comb
    begin
        if (cls_reg == stl_pkg::CLS_NONE)
            cls_app = (is_digit || c == stl_pkg::CH_MINUS) ? stl_pkg::CLS_INT
                                                           : stl_pkg::CLS_STR;
        else if (cls_reg == stl_pkg::CLS_INT && c == stl_pkg::CH_DOT)
            cls_app = stl_pkg::CLS_DBL;
        else
            cls_app = cls_reg;

        rec_echo             = '0;
        rec_echo.record_kind = stl_pkg::KIND_TEXT;
        rec_echo.text_byte   = c;
        rec_echo.line_number = line_reg;
        rec_echo.column      = col_tok;
        unique case (cls_app)
            stl_pkg::CLS_INT: rec_echo.token_class = stl_pkg::CLASS_INT;
            stl_pkg::CLS_DBL: rec_echo.token_class = stl_pkg::CLASS_DOUBLE;
            default:          rec_echo.token_class = stl_pkg::CLASS_STRING;
        endcase

        // Ten times the value plus the digit, checked against the signed limit
        value_wide  = ({4'd0, value_reg} << 3) + ({4'd0, value_reg} << 1) +
                      {64'd0, c[3:0]};
        value_limit = neg_reg ? {4'd0, 1'b1, 63'd0} : {5'd0, {63{1'b1}}};
    end

    // Next state and records for this byte
    always_comb
    begin
        in_quote_next = in_quote_reg;
        cls_next      = cls_reg;
        len_next      = len_reg;
        value_next    = value_reg;
        neg_next      = neg_reg;
        invalid_next  = invalid_reg;
        overflow_next = overflow_reg;
        yes_next      = yes_reg;
        no_next       = no_reg;
        too_long_next = too_long_reg;
        line_next     = line_reg;
        pos_next      = pos_reg;
        n_rec         = 2'd0;
        first_rec     = rec_tok;
        second_rec    = rec_sp;

        priority if (item.stream_end)
        begin
            // Report and return to reset
            n_rec         = 2'd1;
            first_rec     = rec_eos;
            in_quote_next = 1'b0;
            cls_next      = stl_pkg::CLS_NONE;
            len_next      = '0;
            value_next    = '0;
            neg_next      = 1'b0;
            invalid_next  = 1'b0;
            overflow_next = 1'b0;
            yes_next      = 1'b1;
            no_next       = 1'b1;
            too_long_next = 1'b0;
            line_next     = 32'd1;
            pos_next      = '0;
        end
        else
        begin
            if ((in_quote_reg || !(has_sp || is_space)) && c == stl_pkg::CH_QUOTE &&
                !in_quote_reg)
            begin
                // Open a quote: force string, no record
                in_quote_next = 1'b1;
                cls_next      = stl_pkg::CLS_STR;
            end
            else if ((in_quote_reg || !(has_sp || is_space)) && c != stl_pkg::CH_QUOTE)
            begin
                // Append the byte and echo it
                n_rec         = 2'd1;
                first_rec     = rec_echo;
                yes_next      = yes_reg && (len_reg < 32'd3) && (lc == yes_char);
                no_next       = no_reg && (len_reg < 32'd2) && (lc == no_char);
                len_next      = len_reg + 32'd1;
                too_long_next = too_long_reg || (len_next >= 32'(MAX_STRING_BYTES));
                cls_next      = cls_app;
                if (cls_app == stl_pkg::CLS_INT)
                begin
                    if (len_reg == 32'd0 && c == stl_pkg::CH_MINUS)
                        neg_next = 1'b1;
                    else if (is_digit)
                    begin
                        if (!overflow_reg)
                        begin
                            if (value_wide > value_limit)
                                overflow_next = 1'b1;
                            else
                                value_next = value_wide[63:0];
                        end
                    end
                    else
                        invalid_next = 1'b1;
                end
            end
            else
            begin
                // Close a quote or hit a delimiter: finish the token
                if (in_quote_reg)
                    in_quote_next = 1'b0;
                if (cls_reg != stl_pkg::CLS_NONE)
                    n_rec = (has_sp && !in_quote_reg) ? 2'd2 : 2'd1;
                else
                begin
                    first_rec = rec_sp;
                    n_rec     = (has_sp && !in_quote_reg) ? 2'd1 : 2'd0;
                end
                cls_next      = stl_pkg::CLS_NONE;
                len_next      = '0;
                value_next    = '0;
                neg_next      = 1'b0;
                invalid_next  = 1'b0;
                overflow_next = 1'b0;
                yes_next      = 1'b1;
                no_next       = 1'b1;
                too_long_next = 1'b0;
            end

            // Advance the position counters
            if (c == stl_pkg::CH_NL)
            begin
                line_next = line_reg + 32'd1;
                pos_next  = '0;
            end
            else
                pos_next = pos_inc;
        end

        // Mark the last record of this byte
        first_rec.last_of_run  = (n_rec == 2'd1) || item.stream_end;
        second_rec.last_of_run = 1'b1;
    end

    assign push.count  = advance ? n_rec : 2'd0;
    assign push.first  = first_rec;
    assign push.second = second_rec;

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_quote_reg <= 1'b0;
            cls_reg      <= stl_pkg::CLS_NONE;
            len_reg      <= '0;
            value_reg    <= '0;
            neg_reg      <= 1'b0;
            invalid_reg  <= 1'b0;
            overflow_reg <= 1'b0;
            yes_reg      <= 1'b1;
            no_reg       <= 1'b1;
            too_long_reg <= 1'b0;
            line_reg     <= 32'd1;
            pos_reg      <= '0;
        end
        else if (advance)
        begin
            in_quote_reg <= in_quote_next;
            cls_reg      <= cls_next;
            len_reg      <= len_next;
            value_reg    <= value_next;
            neg_reg      <= neg_next;
            invalid_reg  <= invalid_next;
            overflow_reg <= overflow_next;
            yes_reg      <= yes_next;
            no_reg       <= no_next;
            too_long_reg <= too_long_next;
            line_reg     <= line_next;
            pos_reg      <= pos_next;
        end
    end

endmodule

// ----- rtl/stl_result_queue.sv -----
// ----------------------------------------------------------------------------
// stl_result_queue
// Small shifting queue of result records. Takes up to two records a cycle
// from the lexer core and presents the oldest on the output channel.
// ----------------------------------------------------------------------------
module stl_result_queue #(
    parameter int DEPTH = stl_pkg::QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  stl_pkg::lex_push_t push,
    output logic               room,
    output logic               valid,
    input  logic               ready,
    output stl_pkg::lex_out_t  item
);

    localparam int CW = $clog2(DEPTH + 1);

    stl_pkg::lex_out_t slot_reg  [DEPTH];
    stl_pkg::lex_out_t slot_next [DEPTH];
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     base;
    logic              pop;

    assign valid = (count_reg != '0);
    assign item  = slot_reg[0];
    assign pop   = valid && ready;
    assign room  = (count_reg <= CW'(DEPTH - 2));

    // Shift out the head on a pop, then write new records behind the rest
    always_comb
    begin
        base = count_reg - CW'(pop);
        for (int i = 0; i < DEPTH; i++)
        begin
            if (pop && i < DEPTH - 1)
                slot_next[i] = slot_reg[i + 1];
            else
                slot_next[i] = slot_reg[i];
            if (push.count != 2'd0 && CW'(i) == base)
                slot_next[i] = push.first;
            if (push.count == 2'd2 && CW'(i) == base + CW'(1))
                slot_next[i] = push.second;
        end
        count_next = base + CW'(push.count);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
            slot_reg[i] <= slot_next[i];
    end

endmodule

// ----- rtl/script_token_lexer_top.sv -----
// ----------------------------------------------------------------------------
// script_token_lexer_top
// Byte-at-a-time lexer for key-value scripts.
//
// Usage: bytes enter on the byte channel (byte_valid/byte_ready/byte_item);
// records leave on the record channel (record_valid/record_ready/
// record_item). Each byte gives zero, one or two records; last_of_run marks
// the final record of a byte. A request with stream_end set gives one
// end-of-stream record and returns the lexer to its reset state.
// Path: an accepted byte is held in the input register while the lexer works
// on it, and its records are registered into the queue when it advances,
// which waits until the queue has room for two records.
// Throughput: one byte per cycle while each byte gives at most one record
// and the receiver keeps up; the output port moves one record a cycle, so a
// byte giving a token and a special symbol sends them out one after another.
// Reset: line counter 1, column 0, no token open, input register and queue
// empty. When the receiver stalls, the three-entry result queue fills and
// the input register holds its byte; byte_ready falls once the lexer stops.
// ----------------------------------------------------------------------------
module script_token_lexer_top #(
    parameter int QUEUE_DEPTH      = stl_pkg::QUEUE_DEPTH,
    parameter int MAX_STRING_BYTES = stl_pkg::MAX_STRING_BYTES
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_valid,
    output logic              byte_ready,
    input  stl_pkg::lex_in_t  byte_item,
    output logic              record_valid,
    input  logic              record_ready,
    output stl_pkg::lex_out_t record_item
);

    logic               in_valid_reg, in_valid_next;
    stl_pkg::lex_in_t   in_item_reg;
    logic               advance;
    logic               room;
    stl_pkg::lex_push_t push;

    // Advance the buffered byte when the queue has space for two records
    assign advance       = in_valid_reg && room;
    assign byte_ready    = !in_valid_reg || advance;
    assign in_valid_next = (byte_valid && byte_ready) ? 1'b1 :
                           (advance ? 1'b0 : in_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    // Hold the input payload
    always_ff @(posedge clk)
    begin
        if (byte_valid && byte_ready)
            in_item_reg <= byte_item;
    end

    stl_lexer_core #(
        .MAX_STRING_BYTES (MAX_STRING_BYTES)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (in_item_reg),
        .push    (push)
    );

    stl_result_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .room  (room),
        .valid (record_valid),
        .ready (record_ready),
        .item  (record_item)
    );

endmodule

// ----- tb/sv/script_token_lexer_check.sv -----
// ----------------------------------------------------------------------------
// script_token_lexer_check
// Watches both request channels of the script token lexer. Every accepted
// byte is run through a cycle-free model of the lexer. The records that byte
// should produce are queued. Each accepted record is then compared field by
// field with the oldest queued one.
// ----------------------------------------------------------------------------
module script_token_lexer_check (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_valid,
    input  logic              byte_ready,
    input  stl_pkg::lex_in_t  byte_item,
    input  logic              record_valid,
    input  logic              record_ready,
    input  stl_pkg::lex_out_t record_item,
    output int                mismatches,
    output int                pending,
    output int                checked,
    output int                flagged
);
    timeunit 1ns;
    timeprecision 1ps;

    // No special symbol follows the token
    localparam logic [3:0]  NO_SYMBOL   = 4'd0;
    localparam logic [63:0] POS_MAG_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] NEG_MAG_MAX = 64'h8000_0000_0000_0000;

    // Lexer state as the model keeps it
    logic          in_str_quote;
    stl_pkg::cls_t tok_cls;
    logic [31:0]   tok_len;
    logic [63:0]   acc_mag;
    logic          neg_sign;
    logic          bad_digit;
    logic          mag_overflow;
    logic [1:0]    yes_no_ok;
    logic          over_length;
    logic [31:0]   cur_line;
    logic [31:0]   cur_pos;

    stl_pkg::lex_out_t awaited_records[$];

    int fail_total  = 0;
    int seen_total  = 0;
    int error_total = 0;

    assign mismatches = fail_total;
    assign pending    = awaited_records.size();
    assign checked    = seen_total;
    assign flagged    = error_total;

    function automatic logic [3:0] symbol_class(input logic [7:0] c);
        case (c)
            stl_pkg::CH_EQ:     return stl_pkg::CLASS_EQUALS;
            stl_pkg::CH_LBRACE: return stl_pkg::CLASS_LBRACE;
            stl_pkg::CH_RBRACE: return stl_pkg::CLASS_RBRACE;
            stl_pkg::CH_LT:     return stl_pkg::CLASS_LESS;
            stl_pkg::CH_GT:     return stl_pkg::CLASS_GREATER;
            default:            return NO_SYMBOL;
        endcase
    endfunction

    task automatic clear_token();
        tok_cls      = stl_pkg::CLS_NONE;
        tok_len      = '0;
        acc_mag      = '0;
        neg_sign     = 1'b0;
        bad_digit    = 1'b0;
        mag_overflow = 1'b0;
        yes_no_ok    = 2'b11;
        over_length  = 1'b0;
    endtask

    task automatic reset_lexer();
        in_str_quote = 1'b0;
        clear_token();
        cur_line = 32'd1;
        cur_pos  = '0;
    endtask

    task automatic queue_record(input logic [1:0] kind, input logic [3:0] cls,
                                input logic [7:0] chr, input logic [63:0] ival,
                                input logic bval, input logic [31:0] col,
                                input logic [2:0] err);
        stl_pkg::lex_out_t rec;
        rec.record_kind = kind;
        rec.token_class = cls;
        rec.text_byte   = chr;
        rec.int_value   = ival;
        rec.bool_value  = bval;
        rec.line_number = cur_line;
        rec.column      = col;
        rec.error_code  = err;
        rec.last_of_run = 1'b0;
        awaited_records.push_back(rec);
    endtask

    // Emit the finished token, then the symbol that ended it
    task automatic close_token(input logic [3:0] sym);
        logic [31:0] col;
        col = cur_pos - tok_len;
        case (tok_cls)
            stl_pkg::CLS_STR:
            begin
                if (yes_no_ok[0] && tok_len == 32'd3)
                    queue_record(stl_pkg::KIND_TOKEN, stl_pkg::CLASS_BOOL, '0, '0, 1'b1,
                                 col, stl_pkg::ERR_NONE);
                else if (yes_no_ok[1] && tok_len == 32'd2)
                    queue_record(stl_pkg::KIND_TOKEN, stl_pkg::CLASS_BOOL, '0, '0, 1'b0,
                                 col, stl_pkg::ERR_NONE);
                else
                    queue_record(stl_pkg::KIND_TOKEN, stl_pkg::CLASS_STRING, '0, '0, 1'b0,
                                 col, over_length ? stl_pkg::ERR_TOO_LONG
                                                  : stl_pkg::ERR_NONE);
            end
            stl_pkg::CLS_INT:
            begin
                // A bad digit outranks overflow
                if (bad_digit || (neg_sign && tok_len == 32'd1))
                    queue_record(stl_pkg::KIND_TOKEN, stl_pkg::CLASS_INT, '0, '0, 1'b0,
                                 col, stl_pkg::ERR_BAD_INT);
                else if (mag_overflow)
                    queue_record(stl_pkg::KIND_TOKEN, stl_pkg::CLASS_INT, '0, '0, 1'b0,
                                 col, stl_pkg::ERR_OVERFLOW);
                else
                    queue_record(stl_pkg::KIND_TOKEN, stl_pkg::CLASS_INT, '0,
                                 neg_sign ? 64'd0 - acc_mag : acc_mag,
                                 1'b0, col, stl_pkg::ERR_NONE);
            end
            stl_pkg::CLS_DBL:
                queue_record(stl_pkg::KIND_TOKEN, stl_pkg::CLASS_DOUBLE, '0, '0, 1'b0,
                             col, stl_pkg::ERR_NONE);
            default:
            begin
            end
        endcase
        if (sym != NO_SYMBOL)
            queue_record(stl_pkg::KIND_TOKEN, sym, '0, '0, 1'b0, cur_pos,
                         stl_pkg::ERR_NONE);
        clear_token();
    endtask

    // Add one byte to the token in progress
    task automatic grow_token(input logic [7:0] c);
        logic [31:0] idx;
        logic [7:0]  lc;
        logic        digit;
        logic [63:0] d;
        logic [63:0] limit;
        idx   = tok_len;
        lc    = (c >= stl_pkg::CH_UPPER_A && c <= stl_pkg::CH_UPPER_Z) ? c + 8'd32 : c;
        digit = (c >= stl_pkg::CH_ZERO && c <= stl_pkg::CH_NINE);
        d     = {56'd0, c - stl_pkg::CH_ZERO};

        // Track the case-folded match against yes and no
        if (idx >= 32'd3 ||
            lc != (idx == 0 ? stl_pkg::CH_Y : (idx == 1 ? stl_pkg::CH_E : stl_pkg::CH_S)))
            yes_no_ok[0] = 1'b0;
        if (idx >= 32'd2 || lc != (idx == 0 ? stl_pkg::CH_N : stl_pkg::CH_O))
            yes_no_ok[1] = 1'b0;
        tok_len = idx + 32'd1;
        if (tok_len >= stl_pkg::MAX_STRING_BYTES)
            over_length = 1'b1;

        if (tok_cls == stl_pkg::CLS_NONE)
            tok_cls = (digit || c == stl_pkg::CH_MINUS) ? stl_pkg::CLS_INT
                                                        : stl_pkg::CLS_STR;
        else if (tok_cls == stl_pkg::CLS_INT && c == stl_pkg::CH_DOT)
            tok_cls = stl_pkg::CLS_DBL;

        // Accumulate the magnitude of an int, stopping at overflow
        if (tok_cls == stl_pkg::CLS_INT)
        begin
            if (idx == 0 && c == stl_pkg::CH_MINUS)
                neg_sign = 1'b1;
            else if (digit)
            begin
                limit = neg_sign ? NEG_MAG_MAX : POS_MAG_MAX;
                if (!mag_overflow)
                begin
                    if (acc_mag > (limit - d) / 64'd10)
                        mag_overflow = 1'b1;
                    else
                        acc_mag = acc_mag * 64'd10 + d;
                end
            end
            else
                bad_digit = 1'b1;
        end
    endtask

    // Work out the records caused by one accepted request
    task automatic advance_lexer(input stl_pkg::lex_in_t req);
        logic [7:0]        c;
        logic [3:0]        sym;
        logic              delim;
        int                first;
        stl_pkg::lex_out_t rec;
        first = awaited_records.size();
        c     = req.char_byte;
        if (req.stream_end)
        begin
            queue_record(stl_pkg::KIND_EOS, stl_pkg::CLASS_STRING, '0, '0, 1'b0, cur_pos,
                         tok_cls != stl_pkg::CLS_NONE ? stl_pkg::ERR_EOS_OPEN
                                                      : stl_pkg::ERR_NONE);
            reset_lexer();
        end
        else
        begin
            cur_pos = cur_pos + 32'd1;
            sym     = symbol_class(c);
            delim   = (sym != NO_SYMBOL) || c == stl_pkg::CH_SPACE ||
                      (c >= stl_pkg::CH_TAB && c <= stl_pkg::CH_CR);
            if (in_str_quote || !delim)
            begin
                if (c == stl_pkg::CH_QUOTE)
                begin
                    if (in_str_quote)
                    begin
                        in_str_quote = 1'b0;
                        close_token(NO_SYMBOL);
                    end
                    else
                    begin
                        in_str_quote = 1'b1;
                        tok_cls      = stl_pkg::CLS_STR;
                    end
                end
                else
                begin
                    grow_token(c);
                    queue_record(stl_pkg::KIND_TEXT, {2'b00, tok_cls} - 4'd1, c, '0, 1'b0,
                                 cur_pos + 32'd1 - tok_len, stl_pkg::ERR_NONE);
                end
            end
            else
                close_token(sym);
            if (c == stl_pkg::CH_NL)
            begin
                cur_line = cur_line + 32'd1;
                cur_pos  = '0;
            end
        end
        // Mark the final record of this request
        if (awaited_records.size() > first)
        begin
            rec = awaited_records.pop_back();
            rec.last_of_run = 1'b1;
            awaited_records.push_back(rec);
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            $display("%0t: record %0d %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, seen_total, name, want, got);
            fail_total++;
        end
    endtask

    // Predict on accepted bytes, compare accepted records
    always @(posedge clk or negedge rst_n)
    begin
        stl_pkg::lex_out_t want;
        if (!rst_n)
        begin
            reset_lexer();
            awaited_records.delete();
        end
        else
        begin
            if (byte_valid && byte_ready)
                advance_lexer(byte_item);
            if (record_valid && record_ready)
            begin
                if (awaited_records.size() == 0)
                begin
                    $display("%0t: unexpected record, kind %0d class %0d, none pending",
                             $time, record_item.record_kind, record_item.token_class);
                    fail_total++;
                end
                else
                begin
                    want = awaited_records.pop_front();
                    check_field("record_kind", 64'(want.record_kind),
                                64'(record_item.record_kind));
                    check_field("token_class", 64'(want.token_class),
                                64'(record_item.token_class));
                    check_field("text_byte",   64'(want.text_byte),
                                64'(record_item.text_byte));
                    check_field("int_value",   want.int_value, record_item.int_value);
                    check_field("bool_value",  64'(want.bool_value),
                                64'(record_item.bool_value));
                    check_field("line_number", 64'(want.line_number),
                                64'(record_item.line_number));
                    check_field("column",      64'(want.column),
                                64'(record_item.column));
                    check_field("error_code",  64'(want.error_code),
                                64'(record_item.error_code));
                    check_field("last_of_run", 64'(want.last_of_run),
                                64'(record_item.last_of_run));
                end
                if (record_item.error_code != stl_pkg::ERR_NONE)
                    error_total++;
                seen_total++;
            end
        end
    end

endmodule

// ----- tb/sv/script_token_lexer_top_test.sv -----
// ----------------------------------------------------------------------------
// script_token_lexer_top_test
// Drives the script token lexer with a short directed script, then with
// random scripts built from ints, doubles, bools, plain and quoted strings,
// long strings, noise bytes and stream ends. Both channels idle at random,
// and the receiver sometimes stalls long enough to back up the lexer.
// Checking is done by script_token_lexer_check.
// ----------------------------------------------------------------------------
module script_token_lexer_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TARGET_BYTES = 1350;
    localparam int IDLE_LIMIT   = 1000;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 150;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              byte_valid;
    logic              byte_ready;
    stl_pkg::lex_in_t  byte_item;
    logic              record_valid;
    logic              record_ready;
    stl_pkg::lex_out_t record_item;

    int mismatches;
    int pending;
    int checked;
    int flagged;

    int sent      = 0;
    int eos_sent  = 0;
    bit steady    = 1'b0;

    always #6 clk = ~clk;

    script_token_lexer_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_ready   (byte_ready),
        .byte_item    (byte_item),
        .record_valid (record_valid),
        .record_ready (record_ready),
        .record_item  (record_item)
    );

    script_token_lexer_check u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_ready   (byte_ready),
        .byte_item    (byte_item),
        .record_valid (record_valid),
        .record_ready (record_ready),
        .record_item  (record_item),
        .mismatches   (mismatches),
        .pending      (pending),
        .checked      (checked),
        .flagged      (flagged)
    );

    // Mostly short gaps, a few long ones, none in a steady stretch
    function automatic int sender_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 25);
    endfunction

    function automatic logic [7:0] any_letter();
        logic [7:0] base;
        base = $urandom_range(0, 1) ? stl_pkg::CH_UPPER_A : (stl_pkg::CH_UPPER_A | 8'h20);
        return base + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] any_delimiter();
        case ($urandom_range(0, 10))
            0:       return stl_pkg::CH_SPACE;
            1:       return stl_pkg::CH_TAB;
            2:       return stl_pkg::CH_TAB + 8'd2;
            3:       return stl_pkg::CH_TAB + 8'd3;
            4:       return stl_pkg::CH_CR;
            5:       return stl_pkg::CH_EQ;
            6:       return stl_pkg::CH_LBRACE;
            7:       return stl_pkg::CH_RBRACE;
            8:       return stl_pkg::CH_LT;
            9:       return stl_pkg::CH_GT;
            default: return stl_pkg::CH_NL;
        endcase
    endfunction

    function automatic logic [7:0] quoted_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        return (b == stl_pkg::CH_QUOTE) ? stl_pkg::CH_QUOTE + 8'd1 : b;
    endfunction

    // Offer one request and hold it until accepted
    task automatic send_req(input logic [7:0] c, input logic eos);
        int gap;
        gap = sender_gap();
        if (gap > 0)
        begin
            byte_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_valid <= 1'b1;
        byte_item  <= {c, eos};
        @(posedge clk);
        while (!byte_ready)
            @(posedge clk);
        sent++;
        if (eos)
            eos_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_req(s[i], 1'b0);
    endtask

    // Flip the case of letters at random
    task automatic send_mixed(input string s);
        logic [7:0] ch;
        for (int i = 0; i < s.len(); i++)
        begin
            ch = s[i];
            if ($urandom_range(0, 1))
                ch = ch ^ 8'h20;
            send_req(ch, 1'b0);
        end
    endtask

    task automatic send_digits(input int n);
        for (int i = 0; i < n; i++)
            send_req(stl_pkg::CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
    endtask

    task automatic send_quoted(input int n);
        send_req(stl_pkg::CH_QUOTE, 1'b0);
        for (int i = 0; i < n; i++)
            send_req(quoted_byte(), 1'b0);
        send_req(stl_pkg::CH_QUOTE, 1'b0);
    endtask

    // One random token, then usually a delimiter
    task automatic send_token();
        int pick;
        int n;
        pick = $urandom_range(0, 99);
        if (pick < 20)
        begin
            if ($urandom_range(0, 3) == 0)
                send_req(stl_pkg::CH_MINUS, 1'b0);
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 25) : $urandom_range(1, 5);
            send_digits(n);
        end
        else if (pick < 28)
        begin
            case ($urandom_range(0, 5))
                0:       send_text("9223372036854775807");
                1:       send_text("9223372036854775808");
                2:       send_text("-9223372036854775808");
                3:       send_text("-9223372036854775809");
                4:       send_text("0");
                default: send_text("-0");
            endcase
        end
        else if (pick < 36)
        begin
            if ($urandom_range(0, 3) == 0)
                send_req(stl_pkg::CH_MINUS, 1'b0);
            send_digits($urandom_range(0, 3));
            send_req(stl_pkg::CH_DOT, 1'b0);
            send_digits($urandom_range(0, 3));
        end
        else if (pick < 44)
        begin
            case ($urandom_range(0, 3))
                0:       send_req(stl_pkg::CH_MINUS, 1'b0);
                1:
                begin
                    send_digits($urandom_range(1, 3));
                    send_req(any_letter(), 1'b0);
                    send_digits($urandom_range(0, 2));
                end
                2:       send_text("7-");
                default:
                begin
                    // overflow and a bad digit together
                    send_digits(21);
                    send_req(any_letter(), 1'b0);
                end
            endcase
        end
        else if (pick < 56)
        begin
            case ($urandom_range(0, 5))
                0, 1:    send_mixed("yes");
                2, 3:    send_mixed("no");
                4:
                begin
                    if ($urandom_range(0, 1))
                        send_mixed("ye");
                    else
                        send_mixed("yesa");
                end
                default:
                begin
                    if ($urandom_range(0, 1))
                        send_mixed("n");
                    else
                        send_mixed("noo");
                end
            endcase
        end
        else if (pick < 76)
        begin
            send_req(any_letter(), 1'b0);
            n = $urandom_range(0, 7);
            for (int i = 0; i < n; i++)
            begin
                case ($urandom_range(0, 7))
                    0:       send_req(stl_pkg::CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
                    1:       send_req($urandom_range(0, 1) ? stl_pkg::CH_MINUS
                                                           : stl_pkg::CH_DOT, 1'b0);
                    default: send_req(any_letter(), 1'b0);
                endcase
            end
        end
        else if (pick < 86)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                send_req(stl_pkg::CH_QUOTE, 1'b0);
                if ($urandom_range(0, 1))
                    send_mixed("yes");
                else
                    send_mixed("no");
                send_req(stl_pkg::CH_QUOTE, 1'b0);
            end
            else
                send_quoted($urandom_range(0, 10));
        end
        else if (pick < 89)
        begin
            // Long strings, half of them around the too-long boundary
            n = $urandom_range(0, 1) ? $urandom_range(62, 66) : $urandom_range(67, 100);
            if ($urandom_range(0, 1))
                send_quoted(n);
            else
                for (int i = 0; i < n; i++)
                    send_req(any_letter(), 1'b0);
        end
        else if (pick < 95)
            send_req(8'($urandom_range(0, 255)), 1'b0);
        else
            send_req(8'($urandom_range(0, 255)), 1'b1);

        pick = $urandom_range(0, 99);
        if (pick < 70)
            send_req(any_delimiter(), 1'b0);
        else if (pick < 80)
            send_req(stl_pkg::CH_NL, 1'b0);
    endtask

    // Receiver: random ready pattern with an occasional long hold-off
    initial
    begin
        int run;
        int stall;
        int r;
        int cyc;
        int next_hold;
        record_ready <= 1'b0;
        cyc       = 0;
        next_hold = $urandom_range(800, 1500);
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
            record_ready <= 1'b1;
            repeat (run) @(posedge clk);
            cyc += run;
            r = $urandom_range(0, 99);
            if (cyc >= next_hold)
            begin
                stall     = HOLD_CYCLES;
                next_hold = cyc + $urandom_range(3000, 5000);
            end
            else if (r < 50)
                stall = 0;
            else if (r < 90)
                stall = $urandom_range(1, 4);
            else
                stall = $urandom_range(8, 40);
            if (stall > 0)
            begin
                record_ready <= 1'b0;
                repeat (stall) @(posedge clk);
                cyc += stall;
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long or the cycle limit is reached
    initial
    begin
        int idle;
        int total;
        idle  = 0;
        total = 0;
        while (idle < IDLE_LIMIT && total < CYCLE_LIMIT)
        begin
            @(posedge clk);
            total++;
            if ((byte_valid && byte_ready) || (record_valid && record_ready))
                idle = 0;
            else
                idle++;
        end
        $display("%0t: watchdog expired after %0d idle cycles, %0d records pending",
                 $time, idle, pending);
        $display("TB_ERROR");
        $finish;
    end

    // Stimulus and verdict
    initial
    begin
        rst_n      = 1'b0;
        byte_valid <= 1'b0;
        byte_item  <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed script
        send_text("-=");            // lone minus, then equals
        send_text("\"\"");          // empty quotes
        send_text("YeS{");          // bool yes in mixed case, open brace
        send_text("nO}");           // bool no, close brace
        send_text("1.<");           // double, less
        send_text("4x>");           // bad int, greater
        send_text("\"a\nb\"");      // newline inside quotes wraps the column
        send_req(8'hFF, 1'b0);      // extreme bytes start a string
        send_req(8'h00, 1'b0);
        send_req(8'hFF, 1'b1);      // stream ends inside a token

        // Random scripts, with steady stretches now and then
        while (sent < TARGET_BYTES)
        begin
            if ($urandom_range(0, 29) == 0)
                steady = !steady;
            send_token();
        end
        send_req(8'($urandom_range(0, 255)), 1'b1);
        byte_valid <= 1'b0;

        // Drain
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d bytes incl. %0d stream ends; %0d records checked, %0d flagged.",
                 sent, eos_sent, checked, flagged);
        $display("Receiver hold-offs of %0d cycles backed the lexer up.", HOLD_CYCLES);
        if (mismatches == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/stl_pkg.sv
rtl/stl_lexer_core.sv
rtl/stl_result_queue.sv
rtl/script_token_lexer_top.sv
tb/sv/script_token_lexer_check.sv
tb/sv/script_token_lexer_top_test.sv
